// ===== src/spde_pkg.sv =====
// Shared types, codes and constants of the shortest-path engine.
`default_nettype none
package spde_pkg;
	localparam int unsigned NODE_W     = 10;
	localparam int unsigned NCFG_W     = 11;
	localparam int unsigned DIST_W     = 31;
	localparam int unsigned WEIGHT_W   = 16;
	localparam int unsigned FILL_W     = 13;
	localparam int unsigned CNT_W      = 12;
	localparam int unsigned SUM_W      = 40;
	localparam int unsigned MAX_NODES  = 1024;
	localparam int unsigned EDGE_DEPTH = 2048;
	localparam int unsigned EDGE_W     = 2 * NODE_W + WEIGHT_W;

	localparam logic [DIST_W-1:0] UNREACH  = 31'h4000_0000;
	localparam logic [NCFG_W-1:0] NCFG_MAX = 11'd1024;
	localparam logic [FILL_W-1:0] FILL_LIM = 13'd4094;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_RD, S_INIT, S_EDGE_RD, S_EDGE_CHK, S_RELAX, S_SCAN, S_SUM
	} state_t;

	typedef enum logic [4:0] {
		DC_NONE, DC_CLEAR, DC_ADD, DC_FILL_CLR, DC_RD_ISSUE, DC_RESP_READ,
		DC_RUN_START, DC_INIT, DC_SEED, DC_EDGE_RD, DC_EDGE_CHK, DC_RELAX,
		DC_SCAN_START, DC_SCAN, DC_SETTLE, DC_SUM_START, DC_SUM, DC_SUM_STORE
	} dp_cmd_t;

	typedef struct packed {
		logic cnt_ge_n;
		logic cnt_full;
		logic edge_end;
		logic hit;
		logic sweep_done;
		logic found;
		logic out_busy;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== src/spde_ctrl.sv =====
// Controller state machine of the shortest-path engine.
`default_nettype none
module spde_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        operation,
	input  wire spde_pkg::dp_stat_t stat,
	output logic                   in_ready,
	output spde_pkg::dp_cmd_t      cmd
);
	spde_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spde_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = spde_pkg::DC_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			spde_pkg::S_CLR: begin
				if (stat.cnt_full) begin
					state_d = spde_pkg::S_IDLE;
				end else begin
					cmd = spde_pkg::DC_CLEAR;
				end
			end
			spde_pkg::S_IDLE: begin
				in_ready = !stat.out_busy;
				if (in_valid && !stat.out_busy) begin
					unique case (operation)
						spde_pkg::OP_ADD:  cmd = spde_pkg::DC_ADD;
						spde_pkg::OP_RUN: begin
							cmd     = spde_pkg::DC_RUN_START;
							state_d = spde_pkg::S_INIT;
						end
						spde_pkg::OP_READ: begin
							cmd     = spde_pkg::DC_RD_ISSUE;
							state_d = spde_pkg::S_RD;
						end
						default: cmd = spde_pkg::DC_FILL_CLR;
					endcase
				end
			end
			spde_pkg::S_RD: begin
				cmd     = spde_pkg::DC_RESP_READ;
				state_d = spde_pkg::S_IDLE;
			end
			spde_pkg::S_INIT: begin
				if (stat.cnt_ge_n) begin
					cmd     = spde_pkg::DC_SEED;
					state_d = spde_pkg::S_EDGE_RD;
				end else begin
					cmd = spde_pkg::DC_INIT;
				end
			end
			spde_pkg::S_EDGE_RD: begin
				if (stat.edge_end) begin
					cmd     = spde_pkg::DC_SCAN_START;
					state_d = spde_pkg::S_SCAN;
				end else begin
					cmd     = spde_pkg::DC_EDGE_RD;
					state_d = spde_pkg::S_EDGE_CHK;
				end
			end
			spde_pkg::S_EDGE_CHK: begin
				cmd     = spde_pkg::DC_EDGE_CHK;
				state_d = stat.hit ? spde_pkg::S_RELAX : spde_pkg::S_EDGE_RD;
			end
			spde_pkg::S_RELAX: begin
				cmd     = spde_pkg::DC_RELAX;
				state_d = spde_pkg::S_EDGE_RD;
			end
			spde_pkg::S_SCAN: begin
				if (!stat.sweep_done) begin
					cmd = spde_pkg::DC_SCAN;
				end else if (stat.found) begin
					cmd     = spde_pkg::DC_SETTLE;
					state_d = spde_pkg::S_EDGE_RD;
				end else begin
					cmd     = spde_pkg::DC_SUM_START;
					state_d = spde_pkg::S_SUM;
				end
			end
			spde_pkg::S_SUM: begin
				if (stat.sweep_done) begin
					cmd     = spde_pkg::DC_SUM_STORE;
					state_d = spde_pkg::S_IDLE;
				end else begin
					cmd = spde_pkg::DC_SUM;
				end
			end
			default: state_d = spde_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/spde_dpath.sv =====
// Datapath of the shortest-path engine: edge and distance memories, counters, result register.
`default_nettype none
module spde_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire spde_pkg::dp_cmd_t               cmd,
	input  wire logic                            cfg_we,
	input  wire logic [spde_pkg::NCFG_W-1:0]     cfg_data,
	input  wire logic [spde_pkg::NODE_W-1:0]     node_a,
	input  wire logic [spde_pkg::NODE_W-1:0]     node_b,
	input  wire logic [spde_pkg::WEIGHT_W-1:0]   weight,
	input  wire logic                            out_ready,
	output spde_pkg::dp_stat_t                   stat,
	output logic                                 out_valid,
	output logic [1:0]                           status,
	output logic [spde_pkg::DIST_W-1:0]          distance,
	output logic [spde_pkg::NCFG_W-1:0]          reachable_count,
	output logic [spde_pkg::SUM_W-1:0]           distance_sum
);
	logic [spde_pkg::DIST_W:0]   dmem [spde_pkg::MAX_NODES];
	logic [spde_pkg::EDGE_W-1:0] emem [spde_pkg::EDGE_DEPTH];

	logic [spde_pkg::DIST_W:0]   drd_q;
	logic [spde_pkg::EDGE_W-1:0] erd_q;
	logic [spde_pkg::NCFG_W-1:0] ncfg_q, eff_n;
	logic [spde_pkg::CNT_W-1:0]  cnt_q;
	logic [spde_pkg::FILL_W-1:0] fill_q;
	logic [spde_pkg::NODE_W-1:0] u_q, v_q, pick_q, pidx_s1, v_nxt;
	logic [spde_pkg::DIST_W-2:0] du_q;
	logic [spde_pkg::DIST_W-1:0] best_q, cand;
	logic                        found_q, pend_s1, oor_q, out_valid_q;
	logic [spde_pkg::SUM_W-1:0]  sum_q, last_sum_q;
	logic [spde_pkg::NCFG_W-1:0] reach_q, last_reach_q;
	logic [1:0]                  status_q, add_status;
	logic [spde_pkg::DIST_W-1:0] distance_q;
	logic [spde_pkg::SUM_W:0]    sum_add;

	logic                        cnt_ge_n, hit_pre, hit, relax_ok, add_ok;
	logic                        dw_en, dr_en, ew_en, er_en;
	logic [spde_pkg::NODE_W-1:0] dw_addr, dr_addr;
	logic [spde_pkg::DIST_W:0]   dw_data;
	logic [spde_pkg::NODE_W-1:0] ea, eb;
	logic [spde_pkg::WEIGHT_W-1:0] ew;

	always_comb begin
		if (ncfg_q == '0) begin
			eff_n = spde_pkg::NCFG_W'(1);
		end else if (ncfg_q > spde_pkg::NCFG_MAX) begin
			eff_n = spde_pkg::NCFG_MAX;
		end else begin
			eff_n = ncfg_q;
		end
	end

	assign cnt_ge_n = cnt_q >= {1'b0, eff_n};
	assign ea = erd_q[spde_pkg::EDGE_W-1 -: spde_pkg::NODE_W];
	assign eb = erd_q[spde_pkg::WEIGHT_W +: spde_pkg::NODE_W];
	assign ew = erd_q[spde_pkg::WEIGHT_W-1:0];

	always_comb begin
		hit_pre = 1'b0;
		v_nxt   = eb;
		if (ea == u_q && eb != u_q) begin
			hit_pre = 1'b1;
		end else if (eb == u_q && ea != u_q) begin
			hit_pre = 1'b1;
			v_nxt   = ea;
		end
	end
	assign hit = hit_pre && ({1'b0, v_nxt} < eff_n);

	assign cand     = {1'b0, du_q} + {15'd0, ew};
	assign relax_ok = !drd_q[spde_pkg::DIST_W] && !cand[spde_pkg::DIST_W-1]
		&& (cand < drd_q[spde_pkg::DIST_W-1:0]);

	always_comb begin
		if ({1'b0, node_a} >= eff_n || {1'b0, node_b} >= eff_n) begin
			add_status = spde_pkg::ST_RANGE;
		end else if (fill_q > spde_pkg::FILL_LIM) begin
			add_status = spde_pkg::ST_FULL;
		end else begin
			add_status = spde_pkg::ST_OK;
		end
	end
	assign add_ok  = add_status == spde_pkg::ST_OK;
	assign sum_add = {1'b0, sum_q} + {10'd0, drd_q[spde_pkg::DIST_W-1:0]};

	always_comb begin
		dw_en   = 1'b0;
		dw_addr = cnt_q[spde_pkg::NODE_W-1:0];
		dw_data = {1'b0, spde_pkg::UNREACH};
		dr_en   = 1'b0;
		dr_addr = cnt_q[spde_pkg::NODE_W-1:0];
		ew_en   = 1'b0;
		er_en   = 1'b0;
		unique case (cmd)
			spde_pkg::DC_CLEAR: dw_en = 1'b1;
			spde_pkg::DC_INIT: begin
				dw_en = !cnt_ge_n;
				if (cnt_q == '0) begin
					dw_data = {1'b1, {spde_pkg::DIST_W{1'b0}}};
				end
			end
			spde_pkg::DC_SETTLE: begin
				dw_en   = 1'b1;
				dw_addr = pick_q;
				dw_data = {1'b1, best_q};
			end
			spde_pkg::DC_RELAX: begin
				dw_en   = relax_ok;
				dw_addr = v_q;
				dw_data = {1'b0, cand};
			end
			spde_pkg::DC_RD_ISSUE: begin
				dr_en   = 1'b1;
				dr_addr = node_a;
			end
			spde_pkg::DC_SCAN, spde_pkg::DC_SUM: dr_en = !cnt_ge_n;
			spde_pkg::DC_EDGE_CHK: begin
				dr_en   = hit;
				dr_addr = v_nxt;
			end
			spde_pkg::DC_EDGE_RD: er_en = 1'b1;
			spde_pkg::DC_ADD: ew_en = add_ok;
			default: dw_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dw_en) begin
			dmem[dw_addr] <= dw_data;
		end
		if (dr_en) begin
			drd_q <= dmem[dr_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ew_en) begin
			emem[fill_q[11:1]] <= {node_a, node_b, weight};
		end
		if (er_en) begin
			erd_q <= emem[cnt_q[10:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q       <= spde_pkg::NCFG_MAX;
			cnt_q        <= '0;
			fill_q       <= '0;
			u_q          <= '0;
			v_q          <= '0;
			du_q         <= '0;
			pick_q       <= '0;
			pidx_s1      <= '0;
			best_q       <= spde_pkg::UNREACH;
			found_q      <= 1'b0;
			pend_s1      <= 1'b0;
			oor_q        <= 1'b0;
			sum_q        <= '0;
			reach_q      <= '0;
			last_sum_q   <= '0;
			last_reach_q <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= spde_pkg::ST_OK;
			distance_q   <= '0;
		end else begin
			if (cfg_we) begin
				ncfg_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd)
				spde_pkg::DC_CLEAR, spde_pkg::DC_INIT, spde_pkg::DC_RELAX: begin
					cnt_q <= cnt_q + 1'b1;
				end
				spde_pkg::DC_RUN_START: cnt_q <= '0;
				spde_pkg::DC_ADD: begin
					if (add_ok) begin
						fill_q <= fill_q + spde_pkg::FILL_W'(2);
					end
					out_valid_q <= 1'b1;
					status_q    <= add_status;
					distance_q  <= '0;
				end
				spde_pkg::DC_FILL_CLR: begin
					fill_q      <= '0;
					out_valid_q <= 1'b1;
					status_q    <= spde_pkg::ST_OK;
					distance_q  <= '0;
				end
				spde_pkg::DC_RD_ISSUE: oor_q <= {1'b0, node_a} >= eff_n;
				spde_pkg::DC_RESP_READ: begin
					out_valid_q <= 1'b1;
					status_q    <= oor_q ? spde_pkg::ST_RANGE : spde_pkg::ST_OK;
					distance_q  <= oor_q ? spde_pkg::UNREACH : drd_q[spde_pkg::DIST_W-1:0];
				end
				spde_pkg::DC_SEED: begin
					u_q   <= '0;
					du_q  <= '0;
					cnt_q <= '0;
				end
				spde_pkg::DC_EDGE_CHK: begin
					if (hit) begin
						v_q <= v_nxt;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				spde_pkg::DC_SCAN_START: begin
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					best_q  <= spde_pkg::UNREACH;
					found_q <= 1'b0;
				end
				spde_pkg::DC_SCAN: begin
					if (!cnt_ge_n) begin
						cnt_q   <= cnt_q + 1'b1;
						pidx_s1 <= cnt_q[spde_pkg::NODE_W-1:0];
					end
					pend_s1 <= !cnt_ge_n;
					if (pend_s1 && !drd_q[spde_pkg::DIST_W]
						&& drd_q[spde_pkg::DIST_W-1:0] < best_q) begin
						best_q  <= drd_q[spde_pkg::DIST_W-1:0];
						pick_q  <= pidx_s1;
						found_q <= 1'b1;
					end
				end
				spde_pkg::DC_SETTLE: begin
					u_q   <= pick_q;
					du_q  <= best_q[spde_pkg::DIST_W-2:0];
					cnt_q <= '0;
				end
				spde_pkg::DC_SUM_START: begin
					cnt_q   <= '0;
					pend_s1 <= 1'b0;
					sum_q   <= '0;
					reach_q <= '0;
				end
				spde_pkg::DC_SUM: begin
					if (!cnt_ge_n) begin
						cnt_q <= cnt_q + 1'b1;
					end
					pend_s1 <= !cnt_ge_n;
					if (pend_s1 && drd_q[spde_pkg::DIST_W-1:0] < spde_pkg::UNREACH) begin
						sum_q   <= sum_add[spde_pkg::SUM_W] ? '1 : sum_add[spde_pkg::SUM_W-1:0];
						reach_q <= reach_q + 1'b1;
					end
				end
				spde_pkg::DC_SUM_STORE: begin
					last_sum_q   <= sum_q;
					last_reach_q <= reach_q;
					out_valid_q  <= 1'b1;
					status_q     <= spde_pkg::ST_OK;
					distance_q   <= '0;
				end
				default: found_q <= found_q;
			endcase
		end
	end

	assign stat.cnt_ge_n   = cnt_ge_n;
	assign stat.cnt_full   = cnt_q[spde_pkg::NODE_W];
	assign stat.edge_end   = cnt_q >= fill_q[spde_pkg::FILL_W-1:1];
	assign stat.hit        = hit;
	assign stat.sweep_done = cnt_ge_n && !pend_s1;
	assign stat.found      = found_q;
	assign stat.out_busy   = out_valid_q;

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign distance        = distance_q;
	assign reachable_count = last_reach_q;
	assign distance_sum    = last_sum_q;
endmodule
`default_nettype wire

// ===== src/shortest_path_dijkstra_engine_top.sv =====
// Top level of the single-source shortest-path engine.
// After reset the distance memory is swept to unreachable, and the first item is accepted
// no earlier than the end of the sweep. Add and clear items give their result item the cycle
// after they are accepted, and a read item gives it after the distance memory read register
// and the S_RD state. A waiting result item holds ready low, so a new item is taken only
// after the receiver has taken the previous result. A run item walks the array-minimum
// method on one distance memory with a write port and a read port: initialization, then for
// node 0 and each settled node a pass that reads and checks every stored edge and relaxes
// it when it reaches an in-range neighbor, the end of the edge pass and a minimum scan, and
// finally a summing sweep before the result item. Ready stays low for the whole run.
`default_nettype none
module shortest_path_dijkstra_engine_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [spde_pkg::NCFG_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    operation,
	input  wire logic [spde_pkg::NODE_W-1:0]   node_a,
	input  wire logic [spde_pkg::NODE_W-1:0]   node_b,
	input  wire logic [spde_pkg::WEIGHT_W-1:0] weight,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         status,
	output logic [spde_pkg::DIST_W-1:0]        distance,
	output logic [spde_pkg::NCFG_W-1:0]        reachable_count,
	output logic [spde_pkg::SUM_W-1:0]         distance_sum
);
	spde_pkg::dp_cmd_t  cmd;
	spde_pkg::dp_stat_t stat;

	spde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	spde_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.node_a          (node_a),
		.node_b          (node_b),
		.weight          (weight),
		.out_ready       (out_ready),
		.stat            (stat),
		.out_valid       (out_valid),
		.status          (status),
		.distance        (distance),
		.reachable_count (reachable_count),
		.distance_sum    (distance_sum)
	);

	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result item waits");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == spde_pkg::ST_OK || status == spde_pkg::ST_FULL
			|| status == spde_pkg::ST_RANGE))
		else $error("result item carries an undefined status");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && operation == spde_pkg::OP_RUN) |=> !in_ready)
		else $error("ready high right after a run item");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == spde_pkg::ST_RANGE && distance != '0)
			|-> distance == spde_pkg::UNREACH)
		else $error("out-of-range read gave a finite distance");
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the shortest-path engine with its own path predictor.
`timescale 1ns / 100ps
module testbench;
	import spde_pkg::*;

	localparam int unsigned STORE_DEPTH = 4096;
	localparam longint unsigned SUM_CAP = 64'hFF_FFFF_FFFF;

	typedef struct {
		logic [1:0]        status;
		logic [DIST_W-1:0] distance;
		logic [NCFG_W-1:0] reach;
		logic [SUM_W-1:0]  dsum;
	} answer_t;

	class path_scoreboard;
		int unsigned src_of[STORE_DEPTH];
		int unsigned dst_of[STORE_DEPTH];
		int unsigned wgt_of[STORE_DEPTH];
		int unsigned fill;
		int unsigned node_dist[MAX_NODES];
		bit settled[MAX_NODES];
		int unsigned last_reach;
		longint unsigned last_sum;
		int unsigned node_cfg;
		answer_t answers[$];
		int errors;
		int checked;
		int runs;

		function new();
			fill = 0;
			foreach (node_dist[i]) begin
				node_dist[i] = UNREACH;
				settled[i] = 0;
			end
			last_reach = 0;
			last_sum = 0;
			node_cfg = 1024;
			errors = 0;
			checked = 0;
			runs = 0;
		endfunction

		function int unsigned active();
			if (node_cfg == 0) return 1;
			if (node_cfg > MAX_NODES) return MAX_NODES;
			return node_cfg;
		endfunction

		function void relax(int unsigned u, int unsigned n);
			longint unsigned cand;
			for (int unsigned k = 0; k < fill; k++) begin
				if (src_of[k] != u || dst_of[k] >= n) continue;
				if (settled[dst_of[k]] && dst_of[k] != 0) continue;
				if (dst_of[k] == 0 && u != 0) continue;
				cand = longint'(node_dist[u]) + wgt_of[k];
				if (cand < UNREACH && cand < node_dist[dst_of[k]])
					node_dist[dst_of[k]] = int'(cand);
			end
		endfunction

		function void shortest_paths();
			int unsigned n;
			int unsigned best;
			int unsigned pick;
			bit found;
			longint unsigned total;
			int unsigned cnt;
			n = active();
			total = 0;
			cnt = 0;
			for (int unsigned i = 0; i < n; i++) begin
				node_dist[i] = UNREACH;
				settled[i] = 0;
			end
			node_dist[0] = 0;
			settled[0] = 1;
			relax(0, n);
			for (int unsigned s = 1; s < n; s++) begin
				best = UNREACH;
				pick = 0;
				found = 0;
				for (int unsigned i = 0; i < n; i++)
					if (!settled[i] && node_dist[i] < best) begin
						best = node_dist[i];
						pick = i;
						found = 1;
					end
				if (!found) break;
				settled[pick] = 1;
				relax(pick, n);
			end
			for (int unsigned i = 0; i < n; i++)
				if (node_dist[i] < UNREACH) begin
					total += node_dist[i];
					cnt++;
				end
			last_reach = cnt & 11'h7FF;
			last_sum = total > SUM_CAP ? SUM_CAP : total;
		endfunction

		function void note(logic [1:0] op, int unsigned a, int unsigned b, int unsigned w);
			answer_t e;
			int unsigned n;
			n = active();
			e.status = ST_OK;
			e.distance = '0;
			case (op)
				OP_ADD: begin
					if (a >= n || b >= n) e.status = ST_RANGE;
					else if (fill + 2 > STORE_DEPTH) e.status = ST_FULL;
					else begin
						src_of[fill] = a;
						dst_of[fill] = b;
						wgt_of[fill] = w;
						src_of[fill+1] = b;
						dst_of[fill+1] = a;
						wgt_of[fill+1] = w;
						fill += 2;
					end
				end
				OP_RUN: begin
					shortest_paths();
					runs++;
				end
				OP_READ: begin
					if (a >= n) begin
						e.status = ST_RANGE;
						e.distance = UNREACH;
					end else e.distance = node_dist[a];
				end
				default: fill = 0;
			endcase
			e.reach = last_reach;
			e.dsum = last_sum;
			answers.push_back(e);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check(logic [1:0] st, logic [DIST_W-1:0] d, logic [NCFG_W-1:0] r,
				logic [SUM_W-1:0] s);
			answer_t e;
			if (answers.size() == 0) begin
				report("result item with nothing expected");
				return;
			end
			e = answers.pop_front();
			checked++;
			if (st !== e.status || d !== e.distance || r !== e.reach || s !== e.dsum)
				report($sformatf("got st %0d dist %0d reach %0d sum %0d, want %0d %0d %0d %0d",
					st, d, r, s, e.status, e.distance, e.reach, e.dsum));
		endtask

		function int pending();
			return answers.size();
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [NCFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] operation = OP_ADD;
	logic [NODE_W-1:0] node_a = '0;
	logic [NODE_W-1:0] node_b = '0;
	logic [WEIGHT_W-1:0] weight = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic [DIST_W-1:0] distance;
	logic [NCFG_W-1:0] reachable_count;
	logic [SUM_W-1:0] distance_sum;

	path_scoreboard sb = new();
	bit quiet = 0;
	int hold_req = 0;
	int hold_left = 0;

	always #1 clk = ~clk;

	shortest_path_dijkstra_engine_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.node_a(node_a), .node_b(node_b), .weight(weight),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.distance(distance), .reachable_count(reachable_count),
		.distance_sum(distance_sum)
	);

	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check(status, distance, reachable_count, distance_sum);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else out_ready <= quiet || ($urandom_range(99) >= 35);
		end
	end

	task automatic send(logic [1:0] op, int unsigned a, int unsigned b, int unsigned w);
		in_valid <= 1'b1;
		operation <= op;
		node_a <= a[NODE_W-1:0];
		node_b <= b[NODE_W-1:0];
		weight <= w[WEIGHT_W-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note(op, a & 10'h3FF, b & 10'h3FF, w & 16'hFFFF);
		if (!quiet && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_nodes(int unsigned v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v[NCFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.node_cfg = v & 11'h7FF;
		@(posedge clk);
	endtask

	task automatic random_item(int unsigned n, int unsigned span);
		int unsigned r;
		int unsigned w;
		r = $urandom_range(99);
		w = $urandom_range(1) ? $urandom_range(0, 40) : $urandom;
		if (r < 8)
			send($urandom_range(3), $urandom, $urandom, $urandom);
		else if (r < 62)
			send(OP_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1), w);
		else if (r < 66)
			send(OP_RUN, $urandom, $urandom, $urandom);
		else if (r < 98)
			send(OP_READ, $urandom_range(0, n - 1), $urandom, $urandom);
		else
			send(OP_CLEAR, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int unsigned n;
		int unsigned span;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send(OP_READ, 0, 0, 0);
		send(OP_READ, 1023, 1023, 65535);
		send(OP_RUN, 0, 0, 0);
		send(OP_READ, 0, 0, 0);
		send(OP_READ, 5, 0, 0);
		set_nodes(8);
		send(OP_ADD, 8, 1, 5);
		send(OP_ADD, 1, 1023, 5);
		send(OP_ADD, 0, 1, 65535);
		send(OP_ADD, 1, 0, 3);
		send(OP_ADD, 2, 2, 0);
		send(OP_ADD, 1, 2, 0);
		send(OP_ADD, 2, 7, 9);
		send(OP_ADD, 0, 7, 100);
		send(OP_RUN, 0, 0, 0);
		send(OP_READ, 7, 0, 0);
		send(OP_READ, 2, 0, 0);
		send(OP_READ, 8, 0, 0);
		send(OP_READ, 5, 0, 0);
		set_nodes(4);
		send(OP_RUN, 0, 0, 0);
		send(OP_READ, 2, 0, 0);
		send(OP_CLEAR, 0, 0, 0);
		send(OP_READ, 2, 0, 0);
		set_nodes(0);
		send(OP_ADD, 0, 1, 1);
		send(OP_RUN, 0, 0, 0);
		set_nodes(2047);
		send(OP_READ, 1023, 0, 0);

		for (int ph = 0; ph < 14; ph++) begin
			case (ph)
				3: n = 1024;
				6: n = 1;
				9: n = 1024;
				11: n = 2;
				default: n = $urandom_range(2, 24);
			endcase
			set_nodes(n);
			span = (n > 24) ? (($urandom_range(3) == 0) ? 1024 : 32) : n + 1;
			if (ph == 9) span = 1024;
			send(OP_CLEAR, 0, 0, 0);
			quiet = (ph == 5);
			if (ph == 4) hold_req = 400;
			for (int k = 0; k < 140; k++) begin
				random_item(n, span);
				if (ph == 7 && k == 70) drain();
			end
			quiet = 0;
		end

		drain();
		repeat (100) @(posedge clk);
		$display("covered %0d results, %0d shortest-path runs, node counts from 0 to 2047,",
			sb.checked, sb.runs);
		$display("out-of-range endpoints, stale and parallel edges, and long output stalls");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** shortest_path_dijkstra_engine_top: PASSED **");
		else
			$display("** shortest_path_dijkstra_engine_top: FAILED **");
		$finish;
	end

	initial begin
		#40000000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("** shortest_path_dijkstra_engine_top: FAILED **");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/spde_pkg.sv
src/spde_ctrl.sv
src/spde_dpath.sv
src/shortest_path_dijkstra_engine_top.sv
tb/testbench.sv
